// ===== hdl/quaternion_to_axis_angle_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to axis-angle converter
// Implication checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_AXIS_ANGLE_MACROS_SVH
`define QUATERNION_TO_AXIS_ANGLE_MACROS_SVH

// same-cycle implication
`define QAA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QAA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/qaa_pkg.sv =====
// ----------------------------------------------------------------------------
// qaa_pkg
// Payload types, cell data types and CORDIC constants.
// ----------------------------------------------------------------------------
package qaa_pkg;

  localparam int RW = 70;           // root cell accumulator width
  localparam int ROOT_BITS = 28;    // bits of isqrt(d << 24)
  localparam int AXIS_BITS = 17;    // bits of the axis quotient root
  localparam int CW = 34;           // CORDIC datapath width
  localparam int CORDIC_STEPS = 30;
  localparam int PRE_SHIFT = 12;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic [15:0]        rot_angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } axang_t;

  // largest r with r*r*den <= num, built one bit per cell
  typedef struct packed {
    logic [RW-1:0]        p;     // r*r*den
    logic [RW-1:0]        qd;    // r*den
    logic [ROOT_BITS-1:0] root;
    logic [RW-1:0]        num;
    logic [31:0]          den;
  } root_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] ang;
  } cordic_t;

  typedef logic [31:0] atan_tab_t [CORDIC_STEPS];

  localparam atan_tab_t ATAN_TAB = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

endpackage

// ===== hdl/qaa_stream_if.sv =====
// ----------------------------------------------------------------------------
// qaa_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface qaa_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/qaa_root_cell.sv =====
// ----------------------------------------------------------------------------
// qaa_root_cell
// One bit of a root-quotient search: tries setting bit K of the root.
// ----------------------------------------------------------------------------
module qaa_root_cell #(
  parameter int K = 0
) (
  input  logic           clk,
  input  logic           en,
  input  qaa_pkg::root_t din,
  output qaa_pkg::root_t dout
);
  import qaa_pkg::*;

  logic [RW-1:0] den_ext;
  logic [RW-1:0] cand;
  root_t         nxt;

  assign den_ext = RW'(din.den);
  assign cand = din.p + (din.qd << (K + 1)) + (den_ext << (2 * K));

  always_comb begin
    nxt = din;
    if (cand <= din.num) begin
      nxt.p = cand;
      nxt.qd = din.qd + (den_ext << K);
      nxt.root[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule

// ===== hdl/qaa_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// qaa_cordic_cell
// One CORDIC vectoring micro-rotation, step I.
// ----------------------------------------------------------------------------
module qaa_cordic_cell #(
  parameter int I = 0
) (
  input  logic             clk,
  input  logic             en,
  input  qaa_pkg::cordic_t din,
  output qaa_pkg::cordic_t dout
);
  import qaa_pkg::*;

  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic signed [CW-1:0] at;
  cordic_t              nxt;

  assign sx = din.cx >>> I;
  assign sy = din.cy >>> I;
  assign at = CW'(ATAN_TAB[I]);

  always_comb begin
    if (din.cy > 0) begin
      nxt.cx = din.cx + sy;
      nxt.cy = din.cy - sx;
      nxt.ang = din.ang + at;
    end else begin
      nxt.cx = din.cx - sy;
      nxt.cy = din.cy + sx;
      nxt.ang = din.ang - at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule

// ===== hdl/quaternion_to_axis_angle.sv =====
// One item per cycle while the chain is not stalled.
// The cell chain holds 28 square-root cells then 30 CORDIC cells,
// with 17-cell axis root lanes alongside; all stages advance together.
// The chain stalls only while the output register holds an untaken item.
// Reset (rst, synchronous) clears all valid flags; payload is not reset.
// ----------------------------------------------------------------------------
// quaternion_to_axis_angle
// Quaternion in Q2.14 to rotation angle and unit axis, fully pipelined.
// ----------------------------------------------------------------------------
`include "quaternion_to_axis_angle_macros.svh"

module quaternion_to_axis_angle #(
  parameter int FRAC_BITS = 14
) (
  input logic         clk,
  input logic         rst,
  qaa_stream_if.sink   quat_in,
  qaa_stream_if.source axang_out
);
  import qaa_pkg::*;

  localparam logic signed [15:0] ONE = 16'(1 << FRAC_BITS);
  localparam logic signed [15:0] NEG_ONE = -ONE;
  localparam logic [31:0] ONE2 = 32'(1) << (2 * FRAC_BITS);
  localparam int NSD = ROOT_BITS + CORDIC_STEPS;

  typedef struct packed {
    logic signed [15:0]   w;
    logic                 sx;
    logic                 sy;
    logic                 sz;
    logic                 thr;
    logic [AXIS_BITS-1:0] qx;
    logic [AXIS_BITS-1:0] qy;
    logic [AXIS_BITS-1:0] qz;
  } side_t;

  logic en;
  logic o_valid;
  axang_t o_data;

  assign en = !o_valid || axang_out.ready;
  assign quat_in.ready = en;
  assign axang_out.valid = o_valid;
  assign axang_out.data = o_data;

  // stage 1: clamp and products
  logic signed [15:0] wc;
  logic [15:0] mx, my, mz;
  logic signed [31:0] pw, px, py, pz;

  assign wc = (quat_in.data.quat_w < NEG_ONE) ? NEG_ONE : quat_in.data.quat_w;
  assign mx = quat_in.data.quat_x[15] ? 16'(-quat_in.data.quat_x) : quat_in.data.quat_x;
  assign my = quat_in.data.quat_y[15] ? 16'(-quat_in.data.quat_y) : quat_in.data.quat_y;
  assign mz = quat_in.data.quat_z[15] ? 16'(-quat_in.data.quat_z) : quat_in.data.quat_z;
  assign pw = wc * wc;
  assign px = quat_in.data.quat_x * quat_in.data.quat_x;
  assign py = quat_in.data.quat_y * quat_in.data.quat_y;
  assign pz = quat_in.data.quat_z * quat_in.data.quat_z;

  logic s1_v;
  logic signed [15:0] s1_w;
  logic s1_norm, s1_sx, s1_sy, s1_sz;
  logic [31:0] s1_w2, s1_xx, s1_yy, s1_zz;
  logic [29:0] s1_nx, s1_ny, s1_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= quat_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w <= wc;
      s1_norm <= quat_in.data.quat_w > ONE;
      s1_sx <= quat_in.data.quat_x[15];
      s1_sy <= quat_in.data.quat_y[15];
      s1_sz <= quat_in.data.quat_z[15];
      s1_w2 <= $unsigned(pw);
      s1_xx <= $unsigned(px);
      s1_yy <= $unsigned(py);
      s1_zz <= $unsigned(pz);
      s1_nx <= 30'(31'(mx) * 31'd32767);
      s1_ny <= 30'(31'(my) * 31'd32767);
      s1_nz <= 30'(31'(mz) * 31'd32767);
    end
  end

  // stage 2: d, r2 and squared numerators
  logic [31:0] xyz2;
  assign xyz2 = s1_xx + s1_yy + s1_zz;

  logic s2_v;
  logic signed [15:0] s2_w;
  logic s2_sx, s2_sy, s2_sz;
  logic [31:0] s2_d;
  logic [32:0] s2_r2;
  logic [59:0] s2_nnx, s2_nny, s2_nnz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_w <= s1_w;
      s2_sx <= s1_sx;
      s2_sy <= s1_sy;
      s2_sz <= s1_sz;
      if (s1_norm) begin
        s2_d <= xyz2;
        s2_r2 <= 33'(s1_w2) + 33'(xyz2);
      end else begin
        s2_d <= ONE2 - s1_w2;
        s2_r2 <= 33'(ONE2);
      end
      s2_nnx <= s1_nx * s1_nx;
      s2_nny <= s1_ny * s1_ny;
      s2_nnz <= s1_nz * s1_nz;
    end
  end

  // root lanes
  logic [31:0] dv;
  assign dv = (s2_d == 32'd0) ? 32'd1 : s2_d;

  root_t rc_in;
  root_t rc [ROOT_BITS];
  root_t ac_in [3];
  root_t ac [3][AXIS_BITS];

  always_comb begin
    rc_in = '0;
    rc_in.num = RW'(s2_d) << (2 * PRE_SHIFT);
    rc_in.den = 32'd1;
    for (int l = 0; l < 3; l++) begin
      ac_in[l] = '0;
      ac_in[l].den = dv;
    end
    ac_in[0].num = RW'(s2_nnx);
    ac_in[1].num = RW'(s2_nny);
    ac_in[2].num = RW'(s2_nnz);
  end

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
    qaa_root_cell #(.K(ROOT_BITS - 1 - j)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  ((j == 0) ? rc_in : rc[(j == 0) ? 0 : j - 1]),
      .dout (rc[j])
    );
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar j = 0; j < AXIS_BITS; j++) begin : g_axis
      qaa_root_cell #(.K(AXIS_BITS - 1 - j)) u_cell (
        .clk  (clk),
        .en   (en),
        .din  ((j == 0) ? ac_in[l] : ac[l][(j == 0) ? 0 : j - 1]),
        .dout (ac[l][j])
      );
    end
  end

  // side chain
  logic [NSD-1:0] sd_v;
  side_t sd [NSD];
  side_t sd_ax;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_v <= '0;
    end else if (en) begin
      sd_v <= {sd_v[NSD-2:0], s2_v};
    end
  end

  // axis roots join the side chain where the lanes end
  always_comb begin
    sd_ax = sd[AXIS_BITS-1];
    sd_ax.qx = ac[0][AXIS_BITS-1].root[AXIS_BITS-1:0];
    sd_ax.qy = ac[1][AXIS_BITS-1].root[AXIS_BITS-1:0];
    sd_ax.qz = ac[2][AXIS_BITS-1].root[AXIS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0].w <= s2_w;
      sd[0].sx <= s2_sx;
      sd[0].sy <= s2_sy;
      sd[0].sz <= s2_sz;
      sd[0].thr <= (52'(s2_d) * 52'd1000000) < 52'(s2_r2);
      sd[0].qx <= '0;
      sd[0].qy <= '0;
      sd[0].qz <= '0;
      for (int j = 1; j < NSD; j++) begin
        if (j == AXIS_BITS) begin
          sd[j] <= sd_ax;
        end else begin
          sd[j] <= sd[j-1];
        end
      end
    end
  end

  // CORDIC
  cordic_t cc_in;
  cordic_t cc [CORDIC_STEPS];
  logic signed [CW-1:0] cx0, cy0;

  assign cx0 = CW'(sd[ROOT_BITS-1].w) <<< PRE_SHIFT;
  assign cy0 = CW'(rc[ROOT_BITS-1].root);

  always_comb begin
    if (cx0 < 0) begin
      cc_in.cx = cy0;
      cc_in.cy = -cx0;
      cc_in.ang = CW'(1) <<< 30;
    end else begin
      cc_in.cx = cx0;
      cc_in.cy = cy0;
      cc_in.ang = '0;
    end
  end

  for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
    qaa_cordic_cell #(.I(c)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  ((c == 0) ? cc_in : cc[(c == 0) ? 0 : c - 1]),
      .dout (cc[c])
    );
  end

  // output stage
  function automatic logic signed [15:0] sat_axis(input logic [AXIS_BITS-1:0] q,
                                                  input logic neg);
    logic signed [15:0] r;
    if (neg) begin
      r = (q > AXIS_BITS'(32768)) ? -16'sd32768 : 16'(-q);
    end else begin
      r = (q > AXIS_BITS'(32767)) ? 16'sd32767 : 16'(q);
    end
    return r;
  endfunction

  logic signed [CW-1:0] ang_f;
  logic [31:0] ang_c;
  logic [46:0] ang_p;
  side_t sl;

  assign ang_f = cc[CORDIC_STEPS-1].ang;
  assign sl = sd[NSD-1];

  always_comb begin
    if (ang_f < 0) begin
      ang_c = '0;
    end else if (ang_f > (CW'(1) <<< 31)) begin
      ang_c = 32'h8000_0000;
    end else begin
      ang_c = ang_f[31:0];
    end
  end

  assign ang_p = 47'(ang_c) * 47'd32767;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= sd_v[NSD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en && sd_v[NSD-1]) begin
      o_data.rot_angle <= ang_p[45:30];
      if (sl.thr) begin
        o_data.axis_x <= 16'sd32767;
        o_data.axis_y <= '0;
        o_data.axis_z <= '0;
      end else begin
        o_data.axis_x <= sat_axis(sl.qx, sl.sx);
        o_data.axis_y <= sat_axis(sl.qy, sl.sy);
        o_data.axis_z <= sat_axis(sl.qz, sl.sz);
      end
    end
  end

  `QAA_ASSERT_NXT(a_end_loads, sd_v[NSD-1] && en, o_valid, "pipeline end item lost")
  `QAA_ASSERT_NXT(a_drain, o_valid && axang_out.ready && !sd_v[NSD-1], !o_valid,
                  "output repeated")
  `QAA_ASSERT_NXT(a_stall_hold, !en, $stable(sd_v) && $stable(s2_v) && $stable(s1_v),
                  "pipeline moved while stalled")
endmodule
